### rtl/weighted_round_robin_run_queue_macros.svh
// Assertion macros for the weighted round-robin run queue.
// No dependencies; included by the modules that assert.
`ifndef WEIGHTED_ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
// Implication checked on every clock, disabled during reset.
`define WRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define WRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/wrr_rq_pkg.sv
// Shared types and constants for the weighted round-robin run queue.
// No dependencies.
package wrr_rq_pkg;
    localparam int MAX_TASKS_DEF   = 64;
    localparam int SLICE_WIDTH_DEF = 16;
    localparam int ID_W            = 6;
    localparam int CNT_W           = 7;
    localparam int WSUM_W          = 10;
    localparam int CLS_W           = 4;
    localparam logic [CLS_W-1:0] FG_WEIGHT = 4'd10;
    localparam logic [CLS_W-1:0] BG_WEIGHT = 4'd1;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0, OP_DEQ = 2'd1, OP_YIELD = 2'd2, OP_TICK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_QUEUED = 2'd1, ST_NOT_QUEUED = 2'd2, ST_FULL = 2'd3
    } t_status;

    localparam logic [1:0] REG_FG = 2'd0;
    localparam logic [1:0] REG_BG = 2'd1;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] task_id;
        logic            at_head;
        logic            is_background;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic              head_valid;
        logic [ID_W-1:0]   next_task;
        logic [CNT_W-1:0]  queued_count;
        logic [WSUM_W-1:0] weight_sum;
        logic              resched;
        logic [15:0]       slice_left;
    } t_rsp;
endpackage

### rtl/wrr_rq_if.sv
// Valid/ready channel interface for the run queue words.
// No dependencies; the word type is a parameter.
interface wrr_rq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/wrr_rq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrr_rq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/wrr_rq_front.sv
// Front part: accepts request words and holds them in a two-entry queue.
// Depends on wrr_rq_pkg.
module wrr_rq_front
    import wrr_rq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_ready,
    output logic o_valid,
    output t_req o_req,
    input  logic i_pop
);
    t_req r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_rd ^ (r_cnt != 2'd0)] <= i_req;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end
endmodule

### rtl/wrr_rq_back.sv
// Back part: executes one request against the linked list and slice store.
// Depends on wrr_rq_pkg, wrr_rq_ram and the assertion macros.
`include "weighted_round_robin_run_queue_macros.svh"
module wrr_rq_back
    import wrr_rq_pkg::*;
#(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int SLICE_WIDTH = SLICE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_req        i_req,
    output logic        o_pop,
    input  logic [15:0] i_fg_ticks,
    input  logic [15:0] i_bg_ticks,
    output logic        o_valid,
    output t_rsp        o_rsp,
    input  logic        i_ready
);
    localparam int AW = $clog2(MAX_TASKS);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_FIX1, S_FIX2, S_OUT
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic [MAX_TASKS-1:0] r_inq;
    // A class entry is only meaningful once its task has been enqueued.
    logic [MAX_TASKS-1:0] r_seen;
    logic [CLS_W-1:0]     r_w;
    logic [AW-1:0]        r_head, r_tail;
    logic [CNT_W+3:0]     r_count;
    logic [WSUM_W+3:0]    r_wsum;
    logic [1:0]           r_status;
    logic                 r_resched;
    logic [SLICE_WIDTH-1:0] r_slice;
    logic                 r_outv;

    // Pending list edits after unlink, applied in fix cycles.
    logic          r_ins, r_unl;
    logic [AW-1:0] r_p, r_n;
    logic          r_is_h, r_is_t;

    logic          nx_we, pv_we, sl_we, cl_we;
    logic [AW-1:0] nx_wa, pv_wa, sl_wa, nx_ra, pv_ra;
    logic [AW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [SLICE_WIDTH-1:0] sl_wd, sl_rd;
    logic [CLS_W-1:0] cl_rd;

    wrr_rq_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_next (
        .i_clk, .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    wrr_rq_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_prev (
        .i_clk, .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    wrr_rq_ram #(.WIDTH(SLICE_WIDTH), .DEPTH(MAX_TASKS)) u_slice (
        .i_clk, .i_we(sl_we), .i_waddr(sl_wa), .i_wdata(sl_wd),
        .i_raddr(pv_ra), .o_rdata(sl_rd));

    logic          id_ok;
    logic [AW-1:0] id;
    logic [CLS_W-1:0] wnew, wcur;
    logic [SLICE_WIDTH-1:0] rl_new, rl_cur, dec;
    logic [CNT_W+3:0] cnt_max;
    logic          enq_ok;

    wrr_rq_ram #(.WIDTH(CLS_W), .DEPTH(MAX_TASKS)) u_cls (
        .i_clk, .i_we(cl_we), .i_waddr(id), .i_wdata(wnew),
        .i_raddr(pv_ra), .o_rdata(cl_rd));

    assign id_ok  = ({26'd0, r_req.task_id} < 32'(MAX_TASKS));
    assign id     = AW'(r_req.task_id);
    assign wnew   = r_req.is_background ? BG_WEIGHT : FG_WEIGHT;
    assign wcur   = r_seen[id] ? cl_rd : '0;
    assign rl_new = (wnew == BG_WEIGHT) ? SLICE_WIDTH'({16'd0, i_bg_ticks})
                                        : SLICE_WIDTH'({16'd0, i_fg_ticks});
    assign rl_cur = (wcur == BG_WEIGHT) ? SLICE_WIDTH'({16'd0, i_bg_ticks})
                                        : SLICE_WIDTH'({16'd0, i_fg_ticks});
    assign dec    = sl_rd - SLICE_WIDTH'(1);
    assign cnt_max = (CNT_W+4)'(MAX_TASKS);
    assign enq_ok = id_ok && r_req.opcode == OP_ENQ && !r_inq[id] && r_count < cnt_max;
    assign nx_ra  = id;
    assign pv_ra  = id;
    // A new word is taken only once the previous result has left or leaves now.
    assign o_pop  = (r_state == S_IDLE) && i_valid && (!r_outv || i_ready);
    assign o_valid = r_outv;

    // Write ports are decided per state from pending edits.
    always_comb begin
        nx_we = 1'b0; nx_wa = r_p; nx_wd = r_n;
        pv_we = 1'b0; pv_wa = r_n; pv_wd = r_p;
        sl_we = 1'b0; sl_wa = id;  sl_wd = rl_new;
        cl_we = 1'b0;
        case (r_state)
            S_EVAL: begin
                if (enq_ok && wcur != wnew) begin
                    sl_we = 1'b1;
                    cl_we = 1'b1;
                end else if (id_ok && r_req.opcode == OP_TICK && r_inq[id]) begin
                    sl_we = 1'b1;
                    sl_wd = (dec != '0) ? dec : rl_cur;
                end
            end
            S_FIX1: begin
                // Unlink edits.
                if (r_unl && !(r_is_h && r_is_t) && !r_is_h) begin
                    nx_we = 1'b1;
                    nx_wd = r_is_t ? r_p : r_n;
                    pv_we = !r_is_t;
                end
            end
            S_FIX2: begin
                // Insert edits; r_n holds the old head or tail.
                if (r_ins) begin
                    nx_we = 1'b1; nx_wa = id;
                    pv_we = 1'b1; pv_wa = id;
                    if (r_count == '0) begin
                        nx_wd = id; pv_wd = id;
                    end else if (r_req.opcode == OP_ENQ && r_req.at_head) begin
                        nx_wd = r_n; pv_wa = r_n; pv_wd = id;
                    end else begin
                        pv_wd = r_n; nx_wa = r_n; nx_wd = id;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inq   <= '0;
            r_seen  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_wsum  <= '0;
            r_outv  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_req   <= i_req;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_status  <= ST_OK;
                    r_resched <= 1'b0;
                    r_ins <= 1'b0; r_unl <= 1'b0;
                    r_p <= pv_rd; r_n <= nx_rd;
                    r_is_h <= (r_head == id); r_is_t <= (r_tail == id);
                    r_w <= enq_ok ? wnew : wcur;
                    r_state <= S_FIX1;
                    if (!id_ok) begin
                        r_status <= (r_req.opcode == OP_ENQ) ? ST_FULL : ST_NOT_QUEUED;
                    end else if (r_req.opcode == OP_ENQ) begin
                        if (r_inq[id]) r_status <= ST_QUEUED;
                        else if (r_count >= cnt_max) r_status <= ST_FULL;
                        else begin
                            r_seen[id] <= 1'b1;
                            r_ins <= 1'b1;
                            r_n   <= r_req.at_head ? r_head : r_tail;
                        end
                    end else if (!r_inq[id]) begin
                        r_status <= ST_NOT_QUEUED;
                    end else if (r_req.opcode == OP_DEQ) begin
                        r_unl <= 1'b1;
                    end else if (r_req.opcode == OP_YIELD) begin
                        r_unl <= 1'b1; r_ins <= 1'b1;
                    end else if (dec == '0 && r_count > (CNT_W+4)'(1)) begin
                        r_unl <= 1'b1; r_ins <= 1'b1; r_resched <= 1'b1;
                    end
                end
                S_FIX1: begin
                    if (r_unl) begin
                        if (r_is_h && r_is_t) begin
                            r_head <= '0; r_tail <= '0;
                        end else if (r_is_h) r_head <= r_n;
                        else if (r_is_t) r_tail <= r_p;
                        r_count <= r_count - (CNT_W+4)'(1);
                        r_wsum  <= r_wsum - (WSUM_W+4)'(r_w);
                        r_inq[id] <= 1'b0;
                    end
                    // Old tail after unlink, for re-insert.
                    if (r_unl && r_ins) begin
                        r_n <= (r_is_t && !r_is_h) ? r_p : r_tail;
                    end
                    r_state <= S_FIX2;
                end
                S_FIX2: begin
                    if (r_ins) begin
                        if (r_count == '0) begin
                            r_head <= id; r_tail <= id;
                        end else if (r_req.opcode == OP_ENQ && r_req.at_head) r_head <= id;
                        else r_tail <= id;
                        r_count <= r_count + (CNT_W+4)'(1);
                        r_wsum  <= r_wsum + (WSUM_W+4)'(r_w);
                        r_inq[id] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_outv) begin
                        r_outv <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_outv && i_ready) r_outv <= 1'b0;
        end
    end

    // Slice readback in FIX2, once the write in EVAL shows on the registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIX2) r_slice <= sl_rd;
    end

    always_comb begin
        o_rsp.status       = r_status;
        o_rsp.head_valid   = (r_count != '0);
        o_rsp.next_task    = (r_count != '0) ? ID_W'(r_head) : '0;
        o_rsp.queued_count = CNT_W'(r_count);
        o_rsp.weight_sum   = WSUM_W'(r_wsum);
        o_rsp.resched      = r_resched;
        o_rsp.slice_left   = (id_ok && r_w != '0) ? 16'(r_slice) : 16'd0;
    end

    `WRR_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_count <= cnt_max)
    `WRR_ASSERT_IMP(a_empty_wsum, i_clk, i_rst_n, r_count == '0, r_wsum == '0)
    `WRR_ASSERT_NXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state == S_READ)
    `WRR_ASSERT_IMP(a_inq_count, i_clk, i_rst_n, r_state == S_IDLE,
        32'($countones(r_inq)) == 32'(r_count))
endmodule

### rtl/weighted_round_robin_run_queue.sv
// A word passes from acceptance to its result through these steps: dequeue from the
// front queue, RAM read, evaluation, unlink fix, insert fix, output register.
// The back part's sequencer owns the single write port of each link RAM and takes no
// new word until the last result is leaving. The two-entry front queue keeps accepting
// until full while the back part works. Synchronous active-low reset clears the
// queue state and loads the slice registers with 100 and 10; link RAMs are not cleared.
// Depends on wrr_rq_pkg, wrr_rq_if, wrr_rq_front and wrr_rq_back.
module weighted_round_robin_run_queue
    import wrr_rq_pkg::*;
#(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int SLICE_WIDTH = SLICE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrr_rq_if.sink      req_if,
    wrr_rq_if.source    rsp_if,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // Slice reload registers, written over the APB port.
    logic [15:0] r_fg, r_bg;
    logic        f_valid, pop;
    t_req        f_req;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 16'd100;
            r_bg <= 16'd10;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FG[0]) r_fg <= pwdata[15:0];
            if (paddr[2] == REG_BG[0]) r_bg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_FG[0]) prdata = {16'd0, r_fg};
        else prdata = {16'd0, r_bg};
    end

    // Front part classifies nothing beyond buffering; back part executes.
    wrr_rq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(req_if.valid), .i_req(req_if.data), .o_ready(req_if.ready),
        .o_valid(f_valid), .o_req(f_req), .i_pop(pop));

    wrr_rq_back #(.MAX_TASKS(MAX_TASKS), .SLICE_WIDTH(SLICE_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .i_req(f_req), .o_pop(pop),
        .i_fg_ticks(r_fg), .i_bg_ticks(r_bg),
        .o_valid(rsp_if.valid), .o_rsp(rsp_if.data), .i_ready(rsp_if.ready));
endmodule

### tb/weighted_round_robin_run_queue_tb.sv
// Self-checking testbench for the weighted round-robin run queue.
// Depends on wrr_rq_pkg, wrr_rq_if and the weighted_round_robin_run_queue RTL.
`timescale 1ns / 100ps

module weighted_round_robin_run_queue_tb;
    import wrr_rq_pkg::*;

    localparam int NTASK = 64;
    localparam int RANDOM_WORDS = 1450;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // The clock runs with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    wrr_rq_if #(.T(t_req)) req_if ();
    wrr_rq_if #(.T(t_rsp)) rsp_if ();

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_round_robin_run_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req_if  (req_if.sink),
        .rsp_if  (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the scheduler state, updated as each request word is accepted.
    logic [ID_W-1:0]   nxt_link [NTASK];
    logic [ID_W-1:0]   prv_link [NTASK];
    logic [ID_W-1:0]   head_id;
    logic [ID_W-1:0]   tail_id;
    logic              queued [NTASK];
    logic [CLS_W-1:0]  weight_of [NTASK];
    logic [15:0]       slice_of [NTASK];
    int unsigned       n_queued;
    int unsigned       weight_accum;
    logic [15:0]       fg_reload;
    logic [15:0]       bg_reload;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    bit   failed = 1'b0;
    bit   stim_done = 1'b0;
    bit   idle_enable = 1'b1;
    bit   hold_rsp = 1'b0;
    int   src_gap = 0;
    int   sink_gap = 0;

    function automatic logic [15:0] reload_value(logic [CLS_W-1:0] w);
        return (w == BG_WEIGHT) ? bg_reload : fg_reload;
    endfunction

    // Unlinking mirrors the block: a tail removal points the new tail at itself.
    function automatic void unlink_task(logic [ID_W-1:0] t);
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] n;
        p = prv_link[t];
        n = nxt_link[t];
        if (head_id == t && tail_id == t) begin
            head_id = '0;
            tail_id = '0;
        end else if (head_id == t) begin
            head_id = n;
        end else if (tail_id == t) begin
            tail_id = p;
            nxt_link[p] = p;
        end else begin
            nxt_link[p] = n;
            prv_link[n] = p;
        end
    endfunction

    function automatic void link_task(logic [ID_W-1:0] t, bit front, int unsigned others);
        if (others == 0) begin
            head_id = t;
            tail_id = t;
            nxt_link[t] = t;
            prv_link[t] = t;
        end else if (front) begin
            nxt_link[t] = head_id;
            prv_link[head_id] = t;
            head_id = t;
        end else begin
            prv_link[t] = tail_id;
            nxt_link[tail_id] = t;
            tail_id = t;
        end
    endfunction

    // Applies one request word to the shadow state and returns the response it should give.
    function automatic t_rsp schedule_step(t_req r);
        t_rsp o;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] w;
        logic [15:0]      s;
        id = r.task_id;
        o = '0;
        o.status = ST_OK;
        case (t_op'(r.opcode))
            OP_ENQ: begin
                if (queued[id]) begin
                    o.status = ST_QUEUED;
                end else if (n_queued >= NTASK) begin
                    o.status = ST_FULL;
                end else begin
                    w = r.is_background ? BG_WEIGHT : FG_WEIGHT;
                    if (weight_of[id] != w) begin
                        weight_of[id] = w;
                        slice_of[id] = reload_value(w);
                    end
                    link_task(id, r.at_head, n_queued);
                    queued[id] = 1'b1;
                    n_queued++;
                    weight_accum += w;
                end
            end
            default: begin
                if (!queued[id]) begin
                    o.status = ST_NOT_QUEUED;
                end else if (t_op'(r.opcode) == OP_DEQ) begin
                    unlink_task(id);
                    queued[id] = 1'b0;
                    n_queued--;
                    weight_accum -= weight_of[id];
                end else if (t_op'(r.opcode) == OP_YIELD) begin
                    unlink_task(id);
                    link_task(id, 1'b0, n_queued - 1);
                end else begin
                    s = slice_of[id] - 16'd1;
                    if (s != 0) begin
                        slice_of[id] = s;
                    end else begin
                        slice_of[id] = reload_value(weight_of[id]);
                        if (n_queued > 1) begin
                            unlink_task(id);
                            link_task(id, 1'b0, n_queued - 1);
                            o.resched = 1'b1;
                        end
                    end
                end
            end
        endcase
        o.head_valid = (n_queued != 0);
        o.next_task = (n_queued != 0) ? head_id : '0;
        o.queued_count = n_queued[CNT_W-1:0];
        o.weight_sum = weight_accum[WSUM_W-1:0];
        o.slice_left = (weight_of[id] != 0) ? slice_of[id] : 16'd0;
        return o;
    endfunction

    // Driver: offers queued request words with random gaps while idling is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsps.push_back(schedule_step(req_if.data));
            end
            if (req_if.valid && !req_if.ready) begin
                // Hold the word until it is taken.
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_if.valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 5);
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_if.data <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor and sink: random back-pressure, and every response word is
    // compared field by field against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response word %h", got);
                    failed = 1'b1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failed = 1'b1;
                    end
                    if (got.head_valid !== want.head_valid) begin
                        $error("head_valid: expected %0d, got %0d",
                               want.head_valid, got.head_valid);
                        failed = 1'b1;
                    end
                    if (got.next_task !== want.next_task) begin
                        $error("next_task: expected %0d, got %0d",
                               want.next_task, got.next_task);
                        failed = 1'b1;
                    end
                    if (got.queued_count !== want.queued_count) begin
                        $error("queued_count: expected %0d, got %0d",
                               want.queued_count, got.queued_count);
                        failed = 1'b1;
                    end
                    if (got.weight_sum !== want.weight_sum) begin
                        $error("weight_sum: expected %0d, got %0d",
                               want.weight_sum, got.weight_sum);
                        failed = 1'b1;
                    end
                    if (got.resched !== want.resched) begin
                        $error("resched: expected %0d, got %0d", want.resched, got.resched);
                        failed = 1'b1;
                    end
                    if (got.slice_left !== want.slice_left) begin
                        $error("slice_left: expected %0d, got %0d",
                               want.slice_left, got.slice_left);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                rsp_if.ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(0, 5);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // A config write is a setup phase then an access phase; the block is idle here.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_FG) fg_reload = value;
        else bg_reload = value;
    endtask

    // Waits until every issued word has its response, then lets the pipeline settle.
    task automatic drain();
        while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_req make_req(t_op op, int id, bit front, bit bg);
        t_req r;
        r.opcode = op;
        r.task_id = id[ID_W-1:0];
        r.at_head = front;
        r.is_background = bg;
        return r;
    endfunction

    // Random request words. Ids are drawn from a pool whose size varies by
    // phase, so the queue both stays short (frequent slice expiry) and fills up.
    task automatic queue_random(int count, int pool);
        int   roll;
        t_op  op;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) op = OP_ENQ;
            else if (roll < 50) op = OP_DEQ;
            else if (roll < 62) op = OP_YIELD;
            else op = OP_TICK;
            pending_reqs.push_back(make_req(op, $urandom_range(0, pool - 1),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        for (int k = 0; k < NTASK; k++) begin
            queued[k] = 1'b0;
            weight_of[k] = '0;
            slice_of[k] = '0;
            nxt_link[k] = '0;
            prv_link[k] = '0;
        end
        head_id = '0;
        tail_id = '0;
        n_queued = 0;
        weight_accum = 0;
        fg_reload = 16'd100;
        bg_reload = 16'd10;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset reload values: bad requests on an empty
        // queue, a never-seen task, head and tail inserts, a class change,
        // yield, removal from middle and tail, and ticks on a background task's slice.
        pending_reqs.push_back(make_req(OP_DEQ, 63, 0, 0));
        pending_reqs.push_back(make_req(OP_TICK, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_YIELD, 5, 0, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 63, 0, 1));
        pending_reqs.push_back(make_req(OP_ENQ, 0, 1, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 7, 0, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 7, 1, 1));
        pending_reqs.push_back(make_req(OP_YIELD, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_DEQ, 7, 0, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 7, 1, 1));
        pending_reqs.push_back(make_req(OP_TICK, 7, 0, 0));
        for (int k = 0; k < 9; k++) pending_reqs.push_back(make_req(OP_TICK, 63, 0, 0));
        pending_reqs.push_back(make_req(OP_DEQ, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_DEQ, 63, 0, 0));
        drain();

        // Extreme reload values: one tick expires at once; then a zero reload
        // wraps the slice to all ones on the next tick.
        write_reg(REG_FG, 16'd1);
        write_reg(REG_BG, 16'hFFFF);
        pending_reqs.push_back(make_req(OP_ENQ, 20, 0, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 21, 0, 1));
        pending_reqs.push_back(make_req(OP_TICK, 20, 0, 0));
        pending_reqs.push_back(make_req(OP_TICK, 21, 0, 0));
        pending_reqs.push_back(make_req(OP_DEQ, 20, 0, 0));
        pending_reqs.push_back(make_req(OP_TICK, 20, 0, 0));
        drain();
        write_reg(REG_FG, 16'd0);
        pending_reqs.push_back(make_req(OP_ENQ, 20, 1, 1));
        pending_reqs.push_back(make_req(OP_DEQ, 20, 0, 0));
        pending_reqs.push_back(make_req(OP_ENQ, 20, 1, 0));
        pending_reqs.push_back(make_req(OP_TICK, 20, 0, 0));
        drain();

        // Fill the whole queue, then show a full-queue rejection is impossible
        // only by id collision: every id is queued, so enqueue says already queued.
        write_reg(REG_FG, 16'd3);
        write_reg(REG_BG, 16'd2);
        for (int k = 0; k < NTASK; k++)
            pending_reqs.push_back(make_req(OP_ENQ, k, 1'(k % 2), 1'((k / 2) % 2)));
        pending_reqs.push_back(make_req(OP_ENQ, 33, 1, 0));
        queue_random(300, 64);
        drain();

        // Long receiver stall while the sender keeps offering words, so the
        // block's front queue fills and it deasserts ready.
        queue_random(40, 8);
        hold_rsp = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_rsp = 1'b0;
        queue_random(450, 8);
        drain();

        write_reg(REG_FG, 16'd5);
        write_reg(REG_BG, 16'd1);
        queue_random(350, 16);
        drain();

        // Final stretch at full rate on both sides.
        write_reg(REG_FG, 16'd100);
        write_reg(REG_BG, 16'd10);
        idle_enable = 1'b0;
        queue_random(RANDOM_WORDS - 1237, 64);
        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule

### weighted_round_robin_run_queue.f
+incdir+rtl
rtl/wrr_rq_pkg.sv
rtl/wrr_rq_if.sv
rtl/wrr_rq_ram.sv
rtl/wrr_rq_front.sv
rtl/wrr_rq_back.sv
rtl/weighted_round_robin_run_queue.sv
tb/weighted_round_robin_run_queue_tb.sv
